[rtl/shb_pkg.sv]
// ----------------------------------------------------------------------------
// shb_pkg
// Shared types, codes and fixed widths of the spatial histogram binner.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package shb_pkg;

    // Fixed field widths
    localparam int SIZE_W      = 6;
    localparam int DATA_W      = 32;
    localparam int SLICE_W     = 16;
    // Upper bounds that cover every legal parameter setting
    localparam int CELL_W_MAX  = 8;   // cell index for a grid side up to 256
    localparam int SP_W_MAX    = 4;   // species index for up to 16 species
    localparam int PART_W_MAX  = 12;  // particle index for up to 4096 particles
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        FUNC_BIN         = 2'd0,
        FUNC_READ        = 2'd1,
        FUNC_SET_SPECIES = 2'd2,
        FUNC_ADD_NORM    = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        REG_INV_CELL = 2'd0,
        REG_SIZE_X   = 2'd1,
        REG_SIZE_Y   = 2'd2,
        REG_SIZE_Z   = 2'd3
    } t_reg_idx;

    typedef struct packed {
        t_func               func;
        logic signed [31:0]  pos_x;
        logic signed [31:0]  pos_y;
        logic signed [31:0]  pos_z;
        logic [7:0]          particle;
        logic [1:0]          species;
        logic [4:0]          cell_x;
        logic [4:0]          cell_y;
        logic [4:0]          cell_z;
        logic [15:0]         slice_count;
    } t_in_item;

    typedef struct packed {
        logic        status;
        logic [31:0] count;
        logic [31:0] norm_total;
    } t_out_item;

    // Classified request handed from the front to the back
    typedef struct packed {
        t_func                   func;
        logic                    bad;
        logic [SP_W_MAX-1:0]     species;
        logic [PART_W_MAX-1:0]   particle;
        logic [CELL_W_MAX-1:0]   cx;
        logic [CELL_W_MAX-1:0]   cy;
        logic [CELL_W_MAX-1:0]   cz;
        logic [SLICE_W-1:0]      slices;
    } t_cmd;

    typedef enum logic [1:0] {
        FS_IDLE,
        FS_MUL,
        FS_CLS
    } t_front_state;

    typedef enum logic [2:0] {
        BS_CLEAR,
        BS_IDLE,
        BS_MAP,
        BS_RD,
        BS_UPD,
        BS_EXE,
        BS_OUT
    } t_back_state;

endpackage

[rtl/shb_stream_if.sv]
// ----------------------------------------------------------------------------
// shb_stream_if
// Valid/ready channel carrying one payload item per handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface shb_stream_if #(
    parameter type T_DATA = logic
);
    logic  valid;
    logic  ready;
    T_DATA data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/shb_ram.sv]
// ----------------------------------------------------------------------------
// shb_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module shb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/shb_front.sv]
// ----------------------------------------------------------------------------
// shb_front
// Accept an item, scale its position per axis and classify it into a command.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module shb_front import shb_pkg::*; #(
    parameter int GRID_SIDE     = 32,
    parameter int SPECIES_MAX   = 4,
    parameter int PARTICLES_MAX = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    shb_stream_if.sink         i_req,
    input  logic [DATA_W-1:0]  i_inv_cell,
    input  logic [SIZE_W-1:0]  i_size_x,
    input  logic [SIZE_W-1:0]  i_size_y,
    input  logic [SIZE_W-1:0]  i_size_z,
    input  logic               i_hold,
    input  logic               i_full,
    output logic               o_push,
    output t_cmd               o_cmd
);
    typedef struct packed {
        logic                  ok;
        logic [CELL_W_MAX-1:0] idx;
    } t_axis;

    t_front_state r_state, n_state;
    t_in_item     r_in;
    logic [2:0][63:0] r_prod, n_prod;
    logic [2:0]       r_neg, n_neg;
    logic [2:0][31:0] v_pos;
    logic [2:0][31:0] v_mag;
    logic [2:0][5:0]  v_eff;
    t_axis [2:0]      v_axis;
    logic             v_accept;

    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
        return (32'(s) > 32'(GRID_SIDE)) ? SIZE_W'(GRID_SIDE) : s;
    endfunction

    // Cell index on one axis; ok drops when it falls outside [0, size)
    function automatic t_axis axis_cell(input logic [63:0] prod, input logic neg,
                                        input logic [SIZE_W-1:0] eff);
        logic [SIZE_W-1:0] half;
        logic [32:0]       up;
        logic [32:0]       sum;
        t_axis             res;
        half = eff >> 1;
        up   = {1'b0, prod[63:32]} + 33'(prod[31:0] != 32'd0);
        sum  = {1'b0, prod[63:32]} + 33'(half);
        if (neg) begin
            res.ok  = (eff != '0) && (up <= 33'(half));
            res.idx = CELL_W_MAX'(half - up[SIZE_W-1:0]);
        end else begin
            res.ok  = sum < 33'(eff);
            res.idx = CELL_W_MAX'(sum[SIZE_W-1:0]);
        end
        return res;
    endfunction

    assign v_accept = i_req.valid && i_req.ready;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            FS_IDLE: if (v_accept) n_state = FS_MUL;
            FS_MUL:  n_state = FS_CLS;
            FS_CLS:  if (!i_full) n_state = FS_IDLE;
            default: n_state = FS_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        i_req.ready = 1'b0;
        o_push      = 1'b0;
        unique case (r_state)
            FS_IDLE: i_req.ready = !i_hold;
            FS_MUL:  ;
            FS_CLS:  o_push = !i_full;
            default: ;
        endcase
    end

    // Scale each axis by the reciprocal cell size
    always_comb begin
        v_pos[0] = r_in.pos_x;
        v_pos[1] = r_in.pos_y;
        v_pos[2] = r_in.pos_z;
        for (int a = 0; a < 3; a++) begin
            n_neg[a]  = v_pos[a][31];
            v_mag[a]  = v_pos[a][31] ? (32'd0 - v_pos[a]) : v_pos[a];
            n_prod[a] = 64'(v_mag[a]) * 64'(i_inv_cell);
        end
    end

    // Classify
    always_comb begin
        v_eff[0] = eff_size(i_size_x);
        v_eff[1] = eff_size(i_size_y);
        v_eff[2] = eff_size(i_size_z);
        for (int a = 0; a < 3; a++) begin
            v_axis[a] = axis_cell(r_prod[a], r_neg[a], v_eff[a]);
        end
        o_cmd.func     = r_in.func;
        o_cmd.species  = SP_W_MAX'(r_in.species);
        o_cmd.particle = PART_W_MAX'(r_in.particle);
        o_cmd.slices   = r_in.slice_count;
        o_cmd.cx       = CELL_W_MAX'(r_in.cell_x);
        o_cmd.cy       = CELL_W_MAX'(r_in.cell_y);
        o_cmd.cz       = CELL_W_MAX'(r_in.cell_z);
        o_cmd.bad      = 1'b0;
        case (r_in.func)
            FUNC_BIN: begin
                o_cmd.cx  = v_axis[0].idx;
                o_cmd.cy  = v_axis[1].idx;
                o_cmd.cz  = v_axis[2].idx;
                o_cmd.bad = (32'(r_in.particle) >= 32'(PARTICLES_MAX)) ||
                            !v_axis[0].ok || !v_axis[1].ok || !v_axis[2].ok;
            end
            FUNC_READ: begin
                o_cmd.bad = (32'(r_in.species) >= 32'(SPECIES_MAX)) ||
                            (32'(r_in.cell_x) >= 32'(GRID_SIDE)) ||
                            (32'(r_in.cell_y) >= 32'(GRID_SIDE)) ||
                            (32'(r_in.cell_z) >= 32'(GRID_SIDE));
            end
            FUNC_SET_SPECIES: begin
                o_cmd.bad = (32'(r_in.particle) >= 32'(PARTICLES_MAX)) ||
                            (32'(r_in.species) >= 32'(SPECIES_MAX));
            end
            default: o_cmd.bad = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (v_accept) begin
            r_in <= i_req.data;
        end
        if (r_state == FS_MUL) begin
            r_prod <= n_prod;
            r_neg  <= n_neg;
        end
    end
endmodule

[rtl/shb_queue.sv]
// ----------------------------------------------------------------------------
// shb_queue
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module shb_queue import shb_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_cmd o_head
);
    t_cmd       r_mem [QUEUE_DEPTH];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt, n_cnt;

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_full  = (r_cnt == 2'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == 2'd0);
    assign o_head  = r_mem[r_rp];
endmodule

[rtl/shb_back.sv]
// ----------------------------------------------------------------------------
// shb_back
// Carry out commands: species map, histogram read-modify-write, norm sum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module shb_back import shb_pkg::*; #(
    parameter int GRID_SIDE     = 32,
    parameter int SPECIES_MAX   = 4,
    parameter int PARTICLES_MAX = 256
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  t_cmd          i_head,
    output logic          o_pop,
    output logic          o_clearing,
    shb_stream_if.source  o_rsp
);
    localparam int BIN_DEPTH = SPECIES_MAX * GRID_SIDE * GRID_SIDE * GRID_SIDE;
    localparam int AW        = $clog2(BIN_DEPTH);
    localparam int SPW       = (SPECIES_MAX > 1) ? $clog2(SPECIES_MAX) : 1;
    localparam int PW        = (PARTICLES_MAX > 1) ? $clog2(PARTICLES_MAX) : 1;
    localparam int CLR_LEN   = (BIN_DEPTH > PARTICLES_MAX) ? BIN_DEPTH : PARTICLES_MAX;
    localparam int CLRW      = $clog2(CLR_LEN);

    t_back_state r_state, n_state;
    logic [CLRW-1:0]   r_clr, n_clr;
    t_cmd              r_cmd, n_cmd;
    logic [AW-1:0]     r_addr, n_addr;
    t_out_item         r_out, n_out;
    logic [DATA_W-1:0] r_norm, n_norm;

    logic              map_we;
    logic [PW-1:0]     map_waddr;
    logic [SPW-1:0]    map_wdata;
    logic [SPW-1:0]    map_rdata;
    logic              bin_we;
    logic [AW-1:0]     bin_waddr;
    logic [DATA_W-1:0] bin_wdata;
    logic [DATA_W-1:0] bin_rdata;
    logic [DATA_W-1:0] v_inc;
    logic [DATA_W-1:0] v_sp;
    logic [32:0]       v_norm_sum;

    shb_ram #(.WIDTH(SPW), .DEPTH(PARTICLES_MAX), .AW(PW)) u_map (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (map_waddr),
        .i_wdata (map_wdata),
        .i_raddr (i_head.particle[PW-1:0]),
        .o_rdata (map_rdata)
    );

    shb_ram #(.WIDTH(DATA_W), .DEPTH(BIN_DEPTH), .AW(AW)) u_bins (
        .i_clk   (i_clk),
        .i_we    (bin_we),
        .i_waddr (bin_waddr),
        .i_wdata (bin_wdata),
        .i_raddr (r_addr),
        .o_rdata (bin_rdata)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BS_CLEAR: if (r_clr == CLRW'(CLR_LEN - 1)) n_state = BS_IDLE;
            BS_IDLE: begin
                if (!i_empty) begin
                    if (!i_head.bad && (i_head.func inside {FUNC_BIN, FUNC_READ})) begin
                        n_state = BS_MAP;
                    end else begin
                        n_state = BS_EXE;
                    end
                end
            end
            BS_MAP:  n_state = BS_RD;
            BS_RD:   n_state = BS_UPD;
            BS_UPD:  n_state = BS_OUT;
            BS_EXE:  n_state = BS_OUT;
            BS_OUT:  if (o_rsp.ready) n_state = BS_IDLE;
            default: n_state = BS_IDLE;
        endcase
    end

    // State outputs and datapath
    always_comb begin
        o_pop      = 1'b0;
        n_clr      = r_clr;
        n_cmd      = r_cmd;
        n_addr     = r_addr;
        n_out      = r_out;
        n_norm     = r_norm;
        map_we     = 1'b0;
        map_waddr  = r_cmd.particle[PW-1:0];
        map_wdata  = r_cmd.species[SPW-1:0];
        bin_we     = 1'b0;
        bin_waddr  = r_addr;
        v_inc      = (bin_rdata == '1) ? bin_rdata : bin_rdata + 32'd1;
        bin_wdata  = v_inc;
        v_sp       = (r_cmd.func == FUNC_BIN) ? 32'(map_rdata) : 32'(r_cmd.species);
        v_norm_sum = {1'b0, r_norm} + 33'(r_cmd.slices);
        unique case (r_state)
            BS_CLEAR: begin
                n_clr     = r_clr + CLRW'(1);
                map_we    = 32'(r_clr) < 32'(PARTICLES_MAX);
                map_waddr = r_clr[PW-1:0];
                map_wdata = '0;
                bin_we    = 32'(r_clr) < 32'(BIN_DEPTH);
                bin_waddr = r_clr[AW-1:0];
                bin_wdata = '0;
            end
            BS_IDLE: begin
                o_pop = !i_empty;
                n_cmd = i_head;
            end
            BS_MAP: begin
                n_addr = AW'(((v_sp * 32'(GRID_SIDE) + 32'(r_cmd.cx)) * 32'(GRID_SIDE)
                              + 32'(r_cmd.cy)) * 32'(GRID_SIDE) + 32'(r_cmd.cz));
            end
            BS_RD: ;
            BS_UPD: begin
                bin_we           = (r_cmd.func == FUNC_BIN);
                n_out.status     = 1'b0;
                n_out.count      = (r_cmd.func == FUNC_BIN) ? v_inc : bin_rdata;
                n_out.norm_total = r_norm;
            end
            BS_EXE: begin
                if (r_cmd.func == FUNC_ADD_NORM) begin
                    n_norm = v_norm_sum[32] ? '1 : v_norm_sum[31:0];
                end
                map_we           = (r_cmd.func == FUNC_SET_SPECIES) && !r_cmd.bad;
                n_out.status     = r_cmd.bad;
                n_out.count      = '0;
                n_out.norm_total = n_norm;
            end
            BS_OUT: ;
            default: ;
        endcase
    end

    assign o_rsp.valid = (r_state == BS_OUT);
    assign o_rsp.data  = r_out;
    assign o_clearing  = (r_state == BS_CLEAR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BS_CLEAR;
            r_clr   <= '0;
            r_norm  <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_norm  <= n_norm;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_addr <= n_addr;
        r_out  <= n_out;
    end

    // One result in flight: valid drops right after its handshake
    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.ready) |=> !o_rsp.valid)
        else $error("result still valid after handshake");

    // The norm sum only grows
    a_norm_monotone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_norm >= $past(r_norm)))
        else $error("norm sum decreased");

    // No command leaves the queue during the clearing pass
    a_no_pop_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BS_CLEAR) |-> !o_pop)
        else $error("queue popped while clearing");

    // A binned counter never wraps to zero
    a_bin_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BS_UPD && r_cmd.func == FUNC_BIN) |=> (r_out.count != '0))
        else $error("bin counter wrapped");
endmodule

[rtl/spatial_histogram_binner_top.sv]
// ----------------------------------------------------------------------------
// spatial_histogram_binner_top
// Flow: the front takes an item, scales it and classifies it, and can take the
//   next only after pushing the command; the back pops a command and, for an
//   in-range bin/read-bin item, steps through map read, address, bin read, write
//   back and result; the others go through execute and result, so the histogram
//   read-modify-write sets the rate.
// Reset: synchronous; afterwards a clearing pass zeroes every histogram and species
//   map entry with the input held not ready; configuration writes go through.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spatial_histogram_binner_top import shb_pkg::*; #(
    parameter int GRID_SIDE     = 32,
    parameter int SPECIES_MAX   = 4,
    parameter int PARTICLES_MAX = 256
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Configuration port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    // Request and result channels
    shb_stream_if.sink   i_req,
    shb_stream_if.source o_rsp
);
    // Configuration registers
    logic [DATA_W-1:0] r_inv_cell;
    logic [SIZE_W-1:0] r_size_x;
    logic [SIZE_W-1:0] r_size_y;
    logic [SIZE_W-1:0] r_size_z;
    t_reg_idx          v_reg;
    logic              v_cfg_wr;

    // Front to queue to back
    logic q_push, q_pop, q_full, q_empty;
    t_cmd q_in, q_head;
    logic clearing;

    assign pready   = 1'b1;
    assign v_reg    = t_reg_idx'(paddr[3:2]);
    assign v_cfg_wr = psel && penable && pwrite && pready;

    // Register write: in the access phase after setup, any time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_cell <= 32'd65536;
            r_size_x   <= 6'd32;
            r_size_y   <= 6'd32;
            r_size_z   <= 6'd32;
        end else if (v_cfg_wr) begin
            unique case (v_reg)
                REG_INV_CELL: r_inv_cell <= pwdata;
                REG_SIZE_X:   r_size_x   <= pwdata[SIZE_W-1:0];
                REG_SIZE_Y:   r_size_y   <= pwdata[SIZE_W-1:0];
                REG_SIZE_Z:   r_size_z   <= pwdata[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // Register read-back
    always_comb begin
        unique case (v_reg)
            REG_INV_CELL: prdata = r_inv_cell;
            REG_SIZE_X:   prdata = 32'(r_size_x);
            REG_SIZE_Y:   prdata = 32'(r_size_y);
            REG_SIZE_Z:   prdata = 32'(r_size_z);
            default:      prdata = '0;
        endcase
    end

    // Front: take the item, scale the position, flag out-of-range requests
    shb_front #(
        .GRID_SIDE     (GRID_SIDE),
        .SPECIES_MAX   (SPECIES_MAX),
        .PARTICLES_MAX (PARTICLES_MAX)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (i_req),
        .i_inv_cell (r_inv_cell),
        .i_size_x   (r_size_x),
        .i_size_y   (r_size_y),
        .i_size_z   (r_size_z),
        .i_hold     (clearing),
        .i_full     (q_full),
        .o_push     (q_push),
        .o_cmd      (q_in)
    );

    // Short queue so the front keeps going while a result waits
    shb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    // Back: species lookup, histogram update, norm sum, result register
    shb_back #(
        .GRID_SIDE     (GRID_SIDE),
        .SPECIES_MAX   (SPECIES_MAX),
        .PARTICLES_MAX (PARTICLES_MAX)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (q_empty),
        .i_head     (q_head),
        .o_pop      (q_pop),
        .o_clearing (clearing),
        .o_rsp      (o_rsp)
    );
endmodule

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the spatial histogram binner. A bit-exact predictor
// keeps its own histogram, species map, norm sum and register mirror, and
// works out the result of every request the block accepts. Results are
// compared field by field, in order, against that prediction while both
// channels idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import shb_pkg::*;

    localparam int CLK_HALF        = 10;
    localparam int Q_ONE           = 65536;      // 1.0 in Q16.16
    localparam int GRID            = 32;         // grid side of the block
    localparam int MAX_GAP         = 10;         // longest random idle, cycles
    localparam int SETTLE_CYCLES   = 12;         // extra wait after the last result
    // Cycles with no handshake at all before the run is declared hung. The
    // clearing pass after reset keeps the input closed while it zeroes every bin.
    localparam int WATCHDOG_LIMIT  = 400000;
    localparam int RANDOM_PHASES   = 6;
    localparam int ITEMS_PER_PHASE = 60;
    localparam int HOLD_CYCLES     = 400;        // long receiver hold-off
    localparam int KEY_HISTORY     = 64;
    localparam int NORM_BURST      = 20;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    shb_stream_if #(.T_DATA(t_in_item))  req_if ();
    shb_stream_if #(.T_DATA(t_out_item)) rsp_if ();

    spatial_histogram_binner_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Mirror of the block state and configuration
    // ------------------------------------------------------------------
    // Histogram counters keyed by {species, x, y, z}; a missing key is zero.
    int unsigned   hist_mirror [int unsigned];
    logic [1:0]    species_map [256];
    logic [31:0]   norm_mirror;
    logic [31:0]   inv_cell_cfg;
    logic [5:0]    size_cfg [3];

    // Predicted results, oldest first, and recently hit bins for reads
    t_out_item     expected_results [$];
    int unsigned   binned_keys [$];

    int            error_count = 0;
    bit            sender_idles = 1'b1;
    bit            receiver_idles = 1'b1;
    int            rsp_hold_cycles = 0;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    // Cell index of one axis: exact signed product with the reciprocal,
    // floored toward minus infinity, shifted by half the effective size.
    function automatic bit axis_to_cell(input logic signed [31:0] pos,
                                        input logic [5:0] size_reg,
                                        output logic [4:0] idx);
        longint            eff;
        longint unsigned   mag;
        longint unsigned   prod;
        longint            fl;
        eff  = longint'((size_reg > GRID) ? GRID : int'(size_reg));
        mag  = (pos < 0) ? -longint'(pos) : longint'(pos);
        prod = mag * {32'd0, inv_cell_cfg};
        if (pos < 0) begin
            fl = -longint'((prod + 64'hFFFF_FFFF) >> 32);
        end else begin
            fl = longint'(prod >> 32);
        end
        fl  = fl + eff / 2;
        idx = fl[4:0];
        return (fl >= 0) && (fl < eff);
    endfunction

    // Work out the result of one accepted request and advance the mirror.
    function automatic t_out_item predict_result(input t_in_item it);
        t_out_item         res;
        logic [4:0]        cx;
        logic [4:0]        cy;
        logic [4:0]        cz;
        bit                in_x;
        bit                in_y;
        bit                in_z;
        int unsigned       key;
        longint unsigned   total;
        res = '0;
        case (it.func)
            FUNC_BIN: begin
                in_x = axis_to_cell(it.pos_x, size_cfg[0], cx);
                in_y = axis_to_cell(it.pos_y, size_cfg[1], cy);
                in_z = axis_to_cell(it.pos_z, size_cfg[2], cz);
                if (in_x && in_y && in_z) begin
                    key = {15'd0, species_map[it.particle], cx, cy, cz};
                    if (!hist_mirror.exists(key)) hist_mirror[key] = 0;
                    // counters stick at all ones
                    if (hist_mirror[key] != 32'hFFFF_FFFF) hist_mirror[key]++;
                    res.count = hist_mirror[key];
                    binned_keys.push_back(key);
                    if (binned_keys.size() > KEY_HISTORY) void'(binned_keys.pop_front());
                end else begin
                    // dropped: outside the grid on some axis
                    res.status = 1'b1;
                end
            end
            FUNC_READ: begin
                key = {15'd0, it.species, it.cell_x, it.cell_y, it.cell_z};
                if (hist_mirror.exists(key)) res.count = hist_mirror[key];
            end
            FUNC_SET_SPECIES: begin
                species_map[it.particle] = it.species;
            end
            FUNC_ADD_NORM: begin
                total = 64'(norm_mirror) + 64'(it.slice_count);
                norm_mirror = (total > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : total[31:0];
            end
            default: ;
        endcase
        res.norm_total = norm_mirror;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Request builders
    // ------------------------------------------------------------------
    // Every field random; callers then fix what the request needs, so the
    // unused fields still toggle.
    function automatic t_in_item random_item();
        t_in_item it;
        it.func        = t_func'($urandom_range(0, 3));
        it.pos_x       = $urandom();
        it.pos_y       = $urandom();
        it.pos_z       = $urandom();
        it.particle    = 8'($urandom_range(0, 255));
        it.species     = 2'($urandom_range(0, 3));
        it.cell_x      = 5'($urandom_range(0, 31));
        it.cell_y      = 5'($urandom_range(0, 31));
        it.cell_z      = 5'($urandom_range(0, 31));
        it.slice_count = 16'($urandom_range(0, 65535));
        return it;
    endfunction

    function automatic t_in_item bin_request(input logic [7:0] part,
                                             input logic signed [31:0] x,
                                             input logic signed [31:0] y,
                                             input logic signed [31:0] z);
        t_in_item it;
        it          = random_item();
        it.func     = FUNC_BIN;
        it.particle = part;
        it.pos_x    = x;
        it.pos_y    = y;
        it.pos_z    = z;
        return it;
    endfunction

    function automatic t_in_item read_request(input logic [1:0] sp, input logic [4:0] x,
                                              input logic [4:0] y, input logic [4:0] z);
        t_in_item it;
        it         = random_item();
        it.func    = FUNC_READ;
        it.species = sp;
        it.cell_x  = x;
        it.cell_y  = y;
        it.cell_z  = z;
        return it;
    endfunction

    function automatic t_in_item species_request(input logic [7:0] part,
                                                 input logic [1:0] sp);
        t_in_item it;
        it          = random_item();
        it.func     = FUNC_SET_SPECIES;
        it.particle = part;
        it.species  = sp;
        return it;
    endfunction

    function automatic t_in_item norm_request(input logic [15:0] slices);
        t_in_item it;
        it             = random_item();
        it.func        = FUNC_ADD_NORM;
        it.slice_count = slices;
        return it;
    endfunction

    // Position whose scaled value lands on or just past the grid on one axis,
    // for whatever reciprocal is loaded.
    function automatic logic signed [31:0] position_near_grid(input logic [5:0] size_reg);
        int     eff;
        longint target;
        longint num;
        eff = (size_reg > GRID) ? GRID : ((size_reg == 0) ? 1 : int'(size_reg));
        if (inv_cell_cfg == 0) return $urandom();
        target = longint'($urandom_range(0, eff + 1)) - eff / 2 - 1;
        num    = (target <<< 32) + longint'($urandom());
        return 32'(num / longint'({32'd0, inv_cell_cfg}));
    endfunction

    function automatic logic signed [31:0] random_position(input logic [5:0] size_reg);
        int mode;
        mode = $urandom_range(0, 99);
        if (mode < 75) return position_near_grid(size_reg);
        if (mode < 90) return $urandom();
        return int'($urandom_range(0, 1 << 22)) - (1 << 21);
    endfunction

    // Half the requests are bins, mostly near the grid; reads mostly aim at bins already hit.
    function automatic t_in_item make_random_request();
        t_in_item    it;
        int          pick;
        int unsigned key;
        it   = random_item();
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            it.func  = FUNC_BIN;
            it.pos_x = random_position(size_cfg[0]);
            it.pos_y = random_position(size_cfg[1]);
            it.pos_z = random_position(size_cfg[2]);
        end else if (pick < 72) begin
            it.func = FUNC_READ;
            if (binned_keys.size() != 0 && $urandom_range(0, 9) < 6) begin
                key        = binned_keys[$urandom_range(0, binned_keys.size() - 1)];
                it.species = key[16:15];
                it.cell_x  = key[14:10];
                it.cell_y  = key[9:5];
                it.cell_z  = key[4:0];
            end
        end else if (pick < 82) begin
            it.func = FUNC_SET_SPECIES;
        end else begin
            it.func = FUNC_ADD_NORM;
        end
        return it;
    endfunction

    function automatic logic [5:0] random_size();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70) return 6'($urandom_range(1, GRID));
        if (pick < 85) return 6'(GRID);
        if (pick < 92) return 6'd0;
        return 6'($urandom_range(GRID + 1, 63));
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic compare_field(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected 0x%08h, actual 0x%08h",
                     $time, field, want, got);
            error_count++;
        end
    endtask

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    // Write one register, then read it back. Psel stays high from the write
    // straight into the read setup; each call first waits for a clock edge with
    // psel low, so that back-to-back calls never lower and raise psel in the same step.
    task automatic write_reg(input t_reg_idx idx, input logic [31:0] value);
        logic [31:0] stored;
        stored = (idx == REG_INV_CELL) ? value : {26'd0, value[5:0]};
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (idx == REG_INV_CELL) begin
            inv_cell_cfg = value;
        end else begin
            size_cfg[int'(idx) - 1] = value[5:0];
        end
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        compare_field("register readback", stored, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Load the whole grid setup; junk in the unused upper bits of the size
    // registers must be dropped by the block.
    task automatic configure_grid(input logic [31:0] inv, input logic [5:0] sx,
                                  input logic [5:0] sy, input logic [5:0] sz);
        logic [31:0] noise;
        noise = $urandom();
        write_reg(REG_INV_CELL, inv);
        write_reg(REG_SIZE_X, {noise[31:6], sx});
        noise = $urandom();
        write_reg(REG_SIZE_Y, {noise[31:6], sy});
        noise = $urandom();
        write_reg(REG_SIZE_Z, {noise[31:6], sz});
    endtask

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------
    // Offer one item after a random gap and hold it until accepted. Valid is
    // left high on return so the next item can follow with no bubble.
    task automatic send_request(input t_in_item item);
        int gap;
        gap = sender_idles ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= item;
        do @(posedge i_clk); while (!req_if.ready);
        expected_results.push_back(predict_result(item));
    endtask

    // Drop valid, then hold until every predicted result has come back and
    // the pipeline has had time to settle.
    task automatic wait_for_results();
        req_if.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Default grid (unit cells, 32 per side): edges of the grid, both ends
    // of the coordinate range, species remap, norm adds.
    task automatic test_directed_defaults();
        configure_grid(Q_ONE, 6'd32, 6'd32, 6'd32);
        send_request(bin_request(8'd0, 0, 0, 0));
        send_request(bin_request(8'd0, 0, 0, 0));
        send_request(read_request(2'd0, 5'd16, 5'd16, 5'd16));
        send_request(read_request(2'd3, 5'd31, 5'd31, 5'd31));
        // lowest and highest cell on an axis
        send_request(bin_request(8'd0, -16 * Q_ONE, 16 * Q_ONE - 1, 0));
        send_request(read_request(2'd0, 5'd0, 5'd31, 5'd16));
        // one step past each edge is dropped
        send_request(bin_request(8'd0, 16 * Q_ONE, 0, 0));
        send_request(bin_request(8'd0, -16 * Q_ONE - 1, 0, 0));
        // coordinate extremes
        send_request(bin_request(8'd0, 32'sh7FFF_FFFF, 0, 0));
        send_request(bin_request(8'd0, 0, 32'sh8000_0000, 0));
        send_request(bin_request(8'd0, 0, 0, 32'sh7FFF_FFFF));
        send_request(bin_request(8'd0, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000));
        // remap the last particle and bin it under its new species
        send_request(species_request(8'd255, 2'd3));
        send_request(bin_request(8'd255, 0, 0, 0));
        send_request(read_request(2'd3, 5'd16, 5'd16, 5'd16));
        send_request(species_request(8'd255, 2'd0));
        send_request(norm_request(16'd0));
        send_request(norm_request(16'hFFFF));
        send_request(norm_request(16'd1));
        wait_for_results();
    endtask

    // Register extremes: single cell, zero size, oversize, zero and maximum
    // reciprocal.
    task automatic test_grid_extremes();
        configure_grid(Q_ONE, 6'd1, 6'd1, 6'd1);
        send_request(bin_request(8'd1, 0, 0, 0));
        send_request(bin_request(8'd1, -1, 0, 0));
        send_request(bin_request(8'd1, Q_ONE, 0, 0));
        send_request(bin_request(8'd1, Q_ONE - 1, Q_ONE - 1, Q_ONE - 1));
        wait_for_results();
        // a zero size drops everything
        configure_grid(Q_ONE, 6'd0, 6'd32, 6'd32);
        send_request(bin_request(8'd1, 0, 0, 0));
        wait_for_results();
        // sizes above the grid side act as the grid side
        configure_grid(Q_ONE, 6'd63, 6'd63, 6'd63);
        send_request(bin_request(8'd2, 15 * Q_ONE, -16 * Q_ONE, 0));
        send_request(bin_request(8'd2, 16 * Q_ONE, 0, 0));
        wait_for_results();
        // zero reciprocal folds every position onto the center cell
        configure_grid(32'd0, 6'd32, 6'd32, 6'd32);
        send_request(bin_request(8'd3, 32'sh7FFF_FFFF, 32'sh8000_0000, 12345));
        wait_for_results();
        // largest reciprocal: smallest step either side of zero
        configure_grid(32'hFFFF_FFFF, 6'd32, 6'd32, 6'd32);
        send_request(bin_request(8'd0, 1, -1, 0));
        send_request(bin_request(8'd0, 16 * Q_ONE, 0, 0));
        send_request(bin_request(8'd0, 17 * Q_ONE, 0, 0));
        wait_for_results();
    endtask

    // Random traffic over several grid setups. One phase runs with no idling
    // on either side, another with the receiver always ready.
    task automatic test_random_phases();
        logic [31:0] inv;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            if (phase == 0) begin
                configure_grid(Q_ONE, 6'd32, 6'd32, 6'd32);
            end else begin
                case ($urandom_range(0, 5))
                    0:       inv = Q_ONE;
                    1:       inv = Q_ONE / 2;
                    2:       inv = Q_ONE * 2;
                    3:       inv = Q_ONE / 8;
                    4:       inv = $urandom_range(1, 4 * Q_ONE);
                    default: inv = $urandom();
                endcase
                configure_grid(inv, random_size(), random_size(), random_size());
            end
            sender_idles   = (phase != 2);
            receiver_idles = (phase != 2) && (phase != 4);
            repeat (ITEMS_PER_PHASE) send_request(make_random_request());
            wait_for_results();
        end
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
    endtask

    // Hold the result side off for a long stretch while requests keep coming,
    // so the block fills up and closes its input.
    task automatic test_backpressure();
        configure_grid(Q_ONE, 6'd32, 6'd32, 6'd32);
        sender_idles    = 1'b0;
        rsp_hold_cycles = HOLD_CYCLES;
        repeat (40) send_request(make_random_request());
        wait_for_results();
        sender_idles = 1'b1;
    endtask

    // Back-to-back maximum norm adds with the receiver always ready, then a norm
    // add of one and a bin that carries the running total.
    task automatic test_norm_burst();
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        repeat (NORM_BURST) send_request(norm_request(16'hFFFF));
        send_request(norm_request(16'd1));
        send_request(bin_request(8'd0, 0, 0, 0));
        wait_for_results();
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Result side: random stalls, long hold-off on request, in-order check
    // ------------------------------------------------------------------
    initial begin : result_checker
        int        stall;
        bit        taken;
        t_out_item got;
        t_out_item want;
        stall = 0;
        forever begin
            @(posedge i_clk);
            taken = rsp_if.valid && rsp_if.ready;
            if (taken) begin
                got = rsp_if.data;
                if (expected_results.size() == 0) begin
                    $display("%0t ns: unexpected result, expected none, actual 0x%h",
                             $time, got);
                    error_count++;
                end else begin
                    want = expected_results.pop_front();
                    compare_field("status", {31'd0, want.status}, {31'd0, got.status});
                    compare_field("count", want.count, got.count);
                    compare_field("norm_total", want.norm_total, got.norm_total);
                end
                stall = receiver_idles ? $urandom_range(0, MAX_GAP) : 0;
            end
            // decide ready for the next edge
            if (rsp_hold_cycles > 0) begin
                rsp_hold_cycles--;
                rsp_if.ready <= 1'b0;
            end else if (stall > 0) begin
                stall--;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run if no item moves on either channel for too long
    // ------------------------------------------------------------------
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("FAILURE");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : main_sequence
        // known values on every input from time zero
        i_rst_n      <= 1'b0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        req_if.valid <= 1'b0;
        req_if.data  <= '0;
        rsp_if.ready <= 1'b0;
        // mirror starts from the reset state
        foreach (species_map[i]) species_map[i] = 2'd0;
        norm_mirror  = '0;
        inv_cell_cfg = Q_ONE;
        size_cfg     = '{6'd32, 6'd32, 6'd32};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_defaults();
        test_grid_extremes();
        test_random_phases();
        test_backpressure();
        test_norm_burst();
        wait_for_results();

        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

[spatial_histogram_binner_top.f]
rtl/shb_pkg.sv
rtl/shb_stream_if.sv
rtl/shb_ram.sv
rtl/shb_front.sv
rtl/shb_queue.sv
rtl/shb_back.sv
rtl/spatial_histogram_binner_top.sv
sim/testbench.sv
